// ===== rtl/kle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_pkg
// shared types, codes and constants of the keystroke line editor
// ----------------------------------------------------------------------------
package kle_pkg;

    localparam int MAX_CHARS_DEFAULT = 64;

    localparam int CHAR_W     = 8;
    localparam int SCAN_W     = 7;
    localparam int COUNT_W    = 7;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [CHAR_W-1:0] ASCII_CR = 8'd13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_CURSOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTER_SCAN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACKSPACE_SCAN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCAN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCAN     = 3'd5;

    // register reset values
    localparam logic [COUNT_W-1:0] MAX_LENGTH_RST     = 7'd64;
    localparam logic [SCAN_W-1:0]  ENTER_SCAN_RST     = 7'd67;
    localparam logic [SCAN_W-1:0]  BACKSPACE_SCAN_RST = 7'd63;
    localparam logic [SCAN_W-1:0]  LEFT_SCAN_RST      = 7'd82;
    localparam logic [SCAN_W-1:0]  RIGHT_SCAN_RST     = 7'd83;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_NONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_VALIDATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CHANGED   = 2'd2;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_code;
        logic [SCAN_W-1:0] scan_code;
    } kle_key_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHAR_W-1:0]   line_char;
        logic                last_of_run;
        logic [COUNT_W-1:0]  line_length;
        logic [COUNT_W-1:0]  cursor_at;
    } kle_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DEL,
        ST_INS,
        ST_PUT,
        ST_RESULT
    } kle_state_t;

endpackage

// ===== rtl/kle_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_stream_if
// valid/ready channel carrying one payload item per handshake
// ----------------------------------------------------------------------------
interface kle_stream_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/kle_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_buffer
// character store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module kle_buffer #(
    parameter int DEPTH = kle_pkg::MAX_CHARS_DEFAULT,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [kle_pkg::CHAR_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [kle_pkg::CHAR_W-1:0] rd_data
);
    import kle_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/keystroke_line_editor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_line_editor
// single-line text entry: insert, delete, cursor moves and line release
// ----------------------------------------------------------------------------
// results: a move, a refused key or an empty enter offers its item from the
//   result state through the output register; enter reads the first character,
//   then gives one per cycle while the downstream side is ready
// throughput: one key at a time; insert shifts the tail up, then puts the char
//   (an append writes at once); delete shifts it down; one character per cycle
// reset: length, cursor and registers cleared to defaults, buffer not cleared
module keystroke_line_editor #(
    parameter int MAX_CHARS = kle_pkg::MAX_CHARS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    kle_stream_if.sink                    key,
    kle_stream_if.source                  result,
    input  logic                          cfg_wr_en,
    input  logic [kle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kle_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kle_pkg::*;

    // address bits for the buffer, count bits for length and cursor
    localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int LW = $clog2(MAX_CHARS + 1);
    // width to compare the max_length register against the line length
    localparam int CW = (LW > COUNT_W) ? LW : COUNT_W;
    localparam logic [CW-1:0] MAX_CHARS_CW = CW'(MAX_CHARS);

    // configuration registers
    logic [COUNT_W-1:0] max_length_reg;
    logic               static_cursor_reg;
    logic [SCAN_W-1:0]  enter_scan_reg;
    logic [SCAN_W-1:0]  backspace_scan_reg;
    logic [SCAN_W-1:0]  left_scan_reg;
    logic [SCAN_W-1:0]  right_scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg     <= MAX_LENGTH_RST;
            static_cursor_reg  <= 1'b0;
            enter_scan_reg     <= ENTER_SCAN_RST;
            backspace_scan_reg <= BACKSPACE_SCAN_RST;
            left_scan_reg      <= LEFT_SCAN_RST;
            right_scan_reg     <= RIGHT_SCAN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MAX_LENGTH:     max_length_reg     <= cfg_data;
                REG_STATIC_CURSOR:  static_cursor_reg  <= cfg_data[0];
                REG_ENTER_SCAN:     enter_scan_reg     <= cfg_data;
                REG_BACKSPACE_SCAN: backspace_scan_reg <= cfg_data;
                REG_LEFT_SCAN:      left_scan_reg      <= cfg_data;
                REG_RIGHT_SCAN:     right_scan_reg     <= cfg_data;
                default:            ; // unused indexes are ignored
            endcase
        end
    end

    // line state and sequencer registers
    kle_state_t         state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      cur_reg, cur_next;
    // buffer index in flight: char under read (enter, delete) or write target (insert)
    logic [LW-1:0]      idx_reg, idx_next;
    logic [CHAR_W-1:0]  ascii_reg, ascii_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    // output register, parts the sequencer from the downstream side
    logic        out_valid_reg, out_valid_next;
    kle_result_t res_reg, res_next;
    logic        res_load;
    logic        slot_free;

    // buffer ports
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    kle_buffer #(
        .DEPTH (MAX_CHARS),
        .AW    (AW)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // key decode, priority enter > backspace > left > right > character
    logic [CW-1:0] limit;
    logic          is_enter;
    logic          is_bs;
    logic          is_left;
    logic          is_right;
    logic          is_char;
    logic          key_take;

    assign limit    = (CW'(max_length_reg) < MAX_CHARS_CW) ? CW'(max_length_reg)
                                                          : MAX_CHARS_CW;
    assign is_enter = (key.data.scan_code == enter_scan_reg) ||
                      (key.data.ascii_code == ASCII_CR);
    assign is_bs    = (key.data.scan_code == backspace_scan_reg);
    assign is_left  = (key.data.scan_code == left_scan_reg);
    assign is_right = (key.data.scan_code == right_scan_reg);
    assign is_char  = (key.data.ascii_code > ASCII_CR) && (CW'(len_reg) < limit);
    assign key_take = (state_reg == ST_IDLE) && key.valid;

    // neighbors of the index, used by the shift loops
    logic [LW-1:0] idx_inc;
    logic [LW-1:0] idx_dec;
    logic [LW-1:0] idx_dec2;
    logic          emit_last;

    assign idx_inc   = idx_reg + LW'(1);
    assign idx_dec   = idx_reg - LW'(1);
    assign idx_dec2  = idx_reg - LW'(2);
    assign emit_last = (idx_inc == len_reg);

    // the output register may be loaded when empty or emptied this cycle
    assign slot_free = !out_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (key.valid)
                begin
                    priority if (is_enter)
                        state_next = (len_reg != '0) ? ST_EMIT : ST_RESULT;
                    else if (is_bs)
                        state_next = (cur_reg != '0 && cur_reg < len_reg) ? ST_DEL
                                                                           : ST_RESULT;
                    else if (is_left || is_right)
                        state_next = ST_RESULT;
                    else if (is_char)
                        state_next = (len_reg > cur_reg) ? ST_INS : ST_RESULT;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free && emit_last)
                    state_next = ST_IDLE;
            end
            ST_DEL:
            begin
                if (idx_inc >= len_reg)
                    state_next = ST_RESULT;
            end
            ST_INS:
            begin
                if (idx_dec <= cur_reg)
                    state_next = ST_PUT;
            end
            ST_PUT:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls and state updates
    always_comb
    begin
        key.ready   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = AW'(cur_reg);
        mem_wdata   = ascii_reg;
        mem_re      = 1'b0;
        mem_raddr   = AW'(idx_reg);
        len_next    = len_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        ascii_next  = ascii_reg;
        status_next = status_reg;
        res_load    = 1'b0;
        res_next    = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                key.ready = 1'b1;
                if (key.valid)
                begin
                    status_next = STATUS_NONE;
                    priority if (is_enter)
                    begin
                        // start reading the first character, empty line just reports
                        status_next = STATUS_VALIDATED;
                        mem_re      = (len_reg != '0);
                        mem_raddr   = '0;
                        idx_next    = '0;
                    end
                    else if (is_bs)
                    begin
                        if (cur_reg != '0 && len_reg != '0)
                        begin
                            if (cur_reg < len_reg)
                            begin
                                // shift the tail down, first read at the cursor
                                mem_re    = 1'b1;
                                mem_raddr = AW'(cur_reg);
                                idx_next  = cur_reg;
                            end
                            else
                            begin
                                // deleting the last character, nothing to shift
                                len_next    = len_reg - LW'(1);
                                cur_next    = cur_reg - LW'(1);
                                status_next = STATUS_CHANGED;
                            end
                        end
                    end
                    else if (is_left)
                    begin
                        if (cur_reg != '0 && !static_cursor_reg)
                            cur_next = cur_reg - LW'(1);
                    end
                    else if (is_right)
                    begin
                        if (cur_reg < len_reg && !static_cursor_reg)
                            cur_next = cur_reg + LW'(1);
                    end
                    else if (is_char)
                    begin
                        ascii_next = key.data.ascii_code;
                        if (len_reg > cur_reg)
                        begin
                            // shift the tail up, first move is last char to length
                            mem_re    = 1'b1;
                            mem_raddr = AW'(len_reg - LW'(1));
                            idx_next  = len_reg;
                        end
                        else
                        begin
                            // append at the end, no shift
                            mem_we      = 1'b1;
                            mem_waddr   = AW'(cur_reg);
                            mem_wdata   = key.data.ascii_code;
                            len_next    = len_reg + LW'(1);
                            cur_next    = cur_reg + LW'(1);
                            status_next = STATUS_CHANGED;
                        end
                    end
                    else
                    begin
                        // control codes and a full line leave everything as it is
                        status_next = STATUS_NONE;
                    end
                end
            end
            ST_EMIT:
            begin
                // read data holds the character at idx until it is sent
                if (slot_free)
                begin
                    res_load             = 1'b1;
                    res_next.status      = STATUS_VALIDATED;
                    res_next.line_char   = mem_rdata;
                    res_next.last_of_run = emit_last;
                    res_next.line_length = COUNT_W'(len_reg);
                    res_next.cursor_at   = COUNT_W'(cur_reg);
                    if (!emit_last)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(idx_inc);
                        idx_next  = idx_inc;
                    end
                end
            end
            ST_DEL:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_dec);
                mem_wdata = mem_rdata;
                if (idx_inc < len_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_inc);
                    idx_next  = idx_inc;
                end
                else
                begin
                    len_next    = len_reg - LW'(1);
                    cur_next    = cur_reg - LW'(1);
                    status_next = STATUS_CHANGED;
                end
            end
            ST_INS:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(idx_reg);
                mem_wdata = mem_rdata;
                if (idx_dec > cur_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_dec2);
                    idx_next  = idx_dec;
                end
            end
            ST_PUT:
            begin
                // the gap at the cursor is open, drop the new character in
                mem_we      = 1'b1;
                mem_waddr   = AW'(cur_reg);
                mem_wdata   = ascii_reg;
                len_next    = len_reg + LW'(1);
                cur_next    = cur_reg + LW'(1);
                status_next = STATUS_CHANGED;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    res_load             = 1'b1;
                    res_next.status      = status_reg;
                    res_next.line_char   = '0;
                    res_next.last_of_run = 1'b1;
                    res_next.line_length = COUNT_W'(len_reg);
                    res_next.cursor_at   = COUNT_W'(cur_reg);
                end
            end
            default:
            begin
                key.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (res_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scratch registers, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ascii_reg  <= ascii_next;
        status_reg <= status_next;
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------

    // cursor stays inside the line and the line inside the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg <= len_reg) && (len_reg <= LW'(MAX_CHARS)))
    else $error("cursor or length out of range");

    // the release sequence only runs over a non-empty line
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (len_reg != '0 && idx_reg < len_reg))
    else $error("line release index out of range");

    // delete shift writes one below a valid index inside the line
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEL) |-> (idx_reg != '0 && idx_reg < len_reg))
    else $error("delete shift index out of range");

    // insert shift target lies above the cursor and within the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INS) |-> (idx_reg > cur_reg && idx_reg < LW'(MAX_CHARS)))
    else $error("insert shift index out of range");

    // a key is only taken in idle, and taking it always starts the sequencer's work
    assert property (@(posedge clk) disable iff (!rst_n)
        key_take |=> (state_reg != ST_IDLE))
    else $error("key taken without starting its work");

endmodule
